// ===== rtl/wcmp_pkg.sv =====
package wcmp_pkg;

	// fixed field widths and lane count
	localparam int HASH_W = 32;
	localparam int STAGE_W = 2;
	localparam int COUNT_W = 3;
	localparam int STATUS_W = 2;
	localparam int LANES = 4;

	// parameter defaults
	localparam int MAX_OPTIONS_DEF = 4;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int PORT_BITS_DEF = 8;

	// modulo pipeline: remainder bits retired per stage
	localparam int DIV_BITS_PER_STAGE = 4;
	localparam int DIV_STAGES = HASH_W / DIV_BITS_PER_STAGE;

	// switch stage codes
	localparam logic [STAGE_W-1:0] STAGE_1 = 2'd1;
	localparam logic [STAGE_W-1:0] STAGE_2 = 2'd2;
	localparam logic [STAGE_W-1:0] STAGE_3 = 2'd3;

	// rotate-left amounts
	localparam int ROT_S2_UP = 4;
	localparam int ROT_S2_DN = 16;
	localparam int ROT_S3_UP = 8;
	localparam int ROT_S3_DN = 12;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 2'd0,
		ST_BAD_STAGE = 2'd1,
		ST_ZERO_WEIGHT = 2'd2
	} status_t;

endpackage

// ===== rtl/wcmp_output_port_select_core.sv =====
// WCMP port selector. One request is taken on any cycle with start high; busy is always
// low since the pipeline never stalls. The result appears with done high for exactly one
// cycle; results come back in request order, one per cycle at most. The path is made of
// two input stages (hash rotate and lane masking, then cumulative weight sums), the
// 8-stage modulo pipeline that retires 4 remainder bits per stage, and one port-select
// output register. Sustained rate: one request per clock.
module wcmp_output_port_select_core import wcmp_pkg::*; #(
	parameter int MAX_OPTIONS = MAX_OPTIONS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
	parameter int PORT_BITS = PORT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [HASH_W-1:0]      flow_hash,
	input  logic [STAGE_W-1:0]     stage,
	input  logic                   uplink,
	input  logic [COUNT_W-1:0]     option_count,
	input  logic [WEIGHT_BITS-1:0] weight_a,
	input  logic [PORT_BITS-1:0]   port_a,
	input  logic [WEIGHT_BITS-1:0] weight_b,
	input  logic [PORT_BITS-1:0]   port_b,
	input  logic [WEIGHT_BITS-1:0] weight_c,
	input  logic [PORT_BITS-1:0]   port_c,
	input  logic [WEIGHT_BITS-1:0] weight_d,
	input  logic [PORT_BITS-1:0]   port_d,
	output logic                   done,
	output logic [PORT_BITS-1:0]   chosen_port,
	output logic [STATUS_W-1:0]    status
);

	localparam int SUM_W = WEIGHT_BITS + 2;
	localparam int PORTS_W = LANES * PORT_BITS;
	localparam int CUMS_W = (LANES - 1) * SUM_W;
	localparam int TAG_W = STATUS_W + CUMS_W + PORTS_W;
	localparam logic [COUNT_W-1:0] COUNT_LIM =
		COUNT_W'((MAX_OPTIONS < LANES) ? MAX_OPTIONS : LANES);

	assign busy = 1'b0;

	// ---- stage 1: rotate hash, mask inactive lanes
	logic [WEIGHT_BITS-1:0] w_in [LANES];
	logic [PORT_BITS-1:0]   p_in [LANES];
	logic [COUNT_W-1:0]     count_sat;
	logic [HASH_W-1:0]      hash_rot;
	logic                   bad_stage;

	assign w_in[0] = weight_a;
	assign w_in[1] = weight_b;
	assign w_in[2] = weight_c;
	assign w_in[3] = weight_d;
	assign p_in[0] = port_a;
	assign p_in[1] = port_b;
	assign p_in[2] = port_c;
	assign p_in[3] = port_d;

	assign count_sat = (option_count > COUNT_LIM) ? COUNT_LIM : option_count;

	always_comb begin
		bad_stage = 1'b0;
		hash_rot = flow_hash;
		unique case (stage)
			STAGE_1: hash_rot = flow_hash;
			STAGE_2: hash_rot = uplink ?
				((flow_hash << ROT_S2_UP) | (flow_hash >> (HASH_W - ROT_S2_UP))) :
				((flow_hash << ROT_S2_DN) | (flow_hash >> (HASH_W - ROT_S2_DN)));
			STAGE_3: hash_rot = uplink ?
				((flow_hash << ROT_S3_UP) | (flow_hash >> (HASH_W - ROT_S3_UP))) :
				((flow_hash << ROT_S3_DN) | (flow_hash >> (HASH_W - ROT_S3_DN)));
			default: bad_stage = 1'b1;
		endcase
	end

	logic                   vld_s1;
	logic [HASH_W-1:0]      hash_s1;
	logic                   bad_s1;
	logic [WEIGHT_BITS-1:0] w_s1 [LANES];
	logic [PORT_BITS-1:0]   p_s1 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		hash_s1 <= hash_rot;
		bad_s1 <= bad_stage;
		for (int i = 0; i < LANES; i++) begin
			// a lane past the count gets weight 0 and can never be picked
			w_s1[i] <= (COUNT_W'(i) < count_sat) ? w_in[i] : '0;
			p_s1[i] <= p_in[i];
		end
	end

	// ---- stage 2: cumulative weight ranges and status
	logic [SUM_W-1:0] cum [LANES];

	always_comb begin
		cum[0] = SUM_W'(w_s1[0]);
		for (int i = 1; i < LANES; i++) begin
			cum[i] = cum[i-1] + SUM_W'(w_s1[i]);
		end
	end

	logic                 vld_s2;
	logic [HASH_W-1:0]    hash_s2;
	logic [SUM_W-1:0]     sum_s2;
	logic [TAG_W-1:0]     tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		hash_s2 <= hash_s1;
		sum_s2 <= cum[LANES-1];
		// bad stage takes precedence over zero total weight
		if (bad_s1) begin
			tag_s2[TAG_W-1 -: STATUS_W] <= ST_BAD_STAGE;
		end else if (cum[LANES-1] == '0) begin
			tag_s2[TAG_W-1 -: STATUS_W] <= ST_ZERO_WEIGHT;
		end else begin
			tag_s2[TAG_W-1 -: STATUS_W] <= ST_OK;
		end
		for (int i = 0; i < LANES - 1; i++) begin
			tag_s2[PORTS_W + i*SUM_W +: SUM_W] <= cum[i];
		end
		for (int i = 0; i < LANES; i++) begin
			tag_s2[i*PORT_BITS +: PORT_BITS] <= p_s1[i];
		end
	end

	// ---- modulo pipeline
	logic                 div_vld;
	logic [SUM_W-1:0]     div_rem;
	logic [TAG_W-1:0]     div_tag;

	wcmp_mod_pipe #(
		.DIVISOR_W (SUM_W),
		.TAG_W     (TAG_W)
	) u_mod (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (vld_s2),
		.in_dividend (hash_s2),
		.in_divisor  (sum_s2),
		.in_tag      (tag_s2),
		.out_vld     (div_vld),
		.out_rem     (div_rem),
		.out_tag     (div_tag)
	);

	// ---- output: first lane whose cumulative bound exceeds the remainder
	status_t              fin_status;
	logic [PORT_BITS-1:0] fin_port;

	always_comb begin
		fin_status = status_t'(div_tag[TAG_W-1 -: STATUS_W]);
		fin_port = div_tag[(LANES-1)*PORT_BITS +: PORT_BITS];
		for (int i = LANES - 2; i >= 0; i--) begin
			if (div_rem < div_tag[PORTS_W + i*SUM_W +: SUM_W]) begin
				fin_port = div_tag[i*PORT_BITS +: PORT_BITS];
			end
		end
		if (fin_status != ST_OK) begin
			fin_port = '0;
		end
	end

	logic                 done_q;
	logic [PORT_BITS-1:0] chosen_port_q;
	logic [STATUS_W-1:0]  status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		chosen_port_q <= fin_port;
		status_q <= fin_status;
	end

	assign done = done_q;
	assign chosen_port = chosen_port_q;
	assign status = status_q;

endmodule

// ===== rtl/wcmp_mod_pipe.sv =====
module wcmp_mod_pipe import wcmp_pkg::*; #(
	parameter int DIVISOR_W = WEIGHT_BITS_DEF + 2,
	parameter int TAG_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic [HASH_W-1:0]    in_dividend,
	input  logic [DIVISOR_W-1:0] in_divisor,
	input  logic [TAG_W-1:0]     in_tag,
	output logic                 out_vld,
	output logic [DIVISOR_W-1:0] out_rem,
	output logic [TAG_W-1:0]     out_tag
);

	// restoring remainder, MSB first; dividend shifts left so the next bit is always on top
	logic                 vld_s [DIV_STAGES];
	logic [HASH_W-1:0]    dvd_s [DIV_STAGES];
	logic [DIVISOR_W-1:0] dsr_s [DIV_STAGES];
	logic [DIVISOR_W-1:0] rem_s [DIV_STAGES];
	logic [TAG_W-1:0]     tag_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic                 vld_in;
		logic [HASH_W-1:0]    dvd_in;
		logic [DIVISOR_W-1:0] dsr_in;
		logic [DIVISOR_W-1:0] rem_in;
		logic [TAG_W-1:0]     tag_in;
		logic [HASH_W-1:0]    dvd_nxt;
		logic [DIVISOR_W-1:0] rem_nxt;

		if (k == 0) begin : g_first
			assign vld_in = in_vld;
			assign dvd_in = in_dividend;
			assign dsr_in = in_divisor;
			assign rem_in = '0;
			assign tag_in = in_tag;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign dvd_in = dvd_s[k-1];
			assign dsr_in = dsr_s[k-1];
			assign rem_in = rem_s[k-1];
			assign tag_in = tag_s[k-1];
		end

		always_comb begin
			logic [DIVISOR_W:0]   t;
			logic [DIVISOR_W-1:0] r;
			logic [HASH_W-1:0]    d;
			r = rem_in;
			d = dvd_in;
			for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
				t = {r, d[HASH_W-1]};
				d = {d[HASH_W-2:0], 1'b0};
				if (t >= {1'b0, dsr_in}) begin
					t = t - {1'b0, dsr_in};
				end
				// r < divisor held before, so t < 2*divisor and fits after subtract
				r = t[DIVISOR_W-1:0];
			end
			rem_nxt = r;
			dvd_nxt = d;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			dvd_s[k] <= dvd_nxt;
			dsr_s[k] <= dsr_in;
			rem_s[k] <= rem_nxt;
			tag_s[k] <= tag_in;
		end
	end

	assign out_vld = vld_s[DIV_STAGES-1];
	assign out_rem = rem_s[DIV_STAGES-1];
	assign out_tag = tag_s[DIV_STAGES-1];

endmodule

// ===== verif/wcmp_output_port_select_core_tb.sv =====
module wcmp_output_port_select_core_tb import wcmp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WB = WEIGHT_BITS_DEF;
	localparam int PB = PORT_BITS_DEF;
	localparam int N_RANDOM = 1700;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [HASH_W-1:0]  hash;
		logic [STAGE_W-1:0] stage;
		logic               up;
		logic [COUNT_W-1:0] count;
		logic [WB-1:0]      w [LANES];
		logic [PB-1:0]      p [LANES];
	} sel_req_t;

	typedef struct {
		logic [PB-1:0] port;
		status_t       st;
	} sel_res_t;

	typedef struct {
		sel_req_t req;
		bit       typed;
		sel_res_t res;
	} sel_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [HASH_W-1:0] flow_hash = '0;
	logic [STAGE_W-1:0] stage = '0;
	logic uplink = 1'b0;
	logic [COUNT_W-1:0] option_count = '0;
	logic [WB-1:0] weight_a = '0;
	logic [PB-1:0] port_a = '0;
	logic [WB-1:0] weight_b = '0;
	logic [PB-1:0] port_b = '0;
	logic [WB-1:0] weight_c = '0;
	logic [PB-1:0] port_c = '0;
	logic [WB-1:0] weight_d = '0;
	logic [PB-1:0] port_d = '0;
	logic done;
	logic [PB-1:0] chosen_port;
	logic [STATUS_W-1:0] status;

	sel_row_t directed_rows[$];
	sel_res_t pending_picks[$];
	int errors = 0;
	int n_sent = 0;
	int n_ok = 0;
	int n_bad_stage = 0;
	int n_zero_weight = 0;
	int cycles = 0;

	wcmp_output_port_select_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.flow_hash(flow_hash),
		.stage(stage),
		.uplink(uplink),
		.option_count(option_count),
		.weight_a(weight_a),
		.port_a(port_a),
		.weight_b(weight_b),
		.port_b(port_b),
		.weight_c(weight_c),
		.port_c(port_c),
		.weight_d(weight_d),
		.port_d(port_d),
		.done(done),
		.chosen_port(chosen_port),
		.status(status)
	);

	always #4 clk = ~clk;

	function automatic sel_res_t pick_port(sel_req_t r);
		sel_res_t res;
		logic [2*HASH_W-1:0] dbl;
		int unsigned amt;
		int unsigned lanes;
		int unsigned sum;
		int unsigned rem;
		res.port = '0;
		res.st = ST_OK;
		case (r.stage)
			STAGE_1: amt = 0;
			STAGE_2: amt = r.up ? ROT_S2_UP : ROT_S2_DN;
			STAGE_3: amt = r.up ? ROT_S3_UP : ROT_S3_DN;
			default: begin
				res.st = ST_BAD_STAGE;
				return res;
			end
		endcase
		lanes = (r.count > MAX_OPTIONS_DEF) ? MAX_OPTIONS_DEF : r.count;
		sum = 0;
		for (int i = 0; i < lanes; i++)
			sum += r.w[i];
		if (sum == 0) begin
			res.st = ST_ZERO_WEIGHT;
			return res;
		end
		// rotate left: upper half of the doubled word shifted by amt
		dbl = {r.hash, r.hash} << amt;
		rem = dbl[2*HASH_W-1:HASH_W] % sum;
		for (int i = 0; i < lanes; i++) begin
			if (rem < r.w[i]) begin
				res.port = r.p[i];
				return res;
			end
			rem -= r.w[i];
		end
		return res;
	endfunction

	// weights and ports packed lane d down to lane a
	task automatic add_row(input logic [HASH_W-1:0] hash, input logic [STAGE_W-1:0] stg,
			input logic up, input logic [COUNT_W-1:0] cnt,
			input logic [4*WB-1:0] wts, input logic [4*PB-1:0] ports,
			input bit typed, input logic [PB-1:0] exp_port, input status_t exp_st);
		sel_row_t row;
		row.req.hash = hash;
		row.req.stage = stg;
		row.req.up = up;
		row.req.count = cnt;
		for (int i = 0; i < LANES; i++) begin
			row.req.w[i] = wts[WB*i +: WB];
			row.req.p[i] = ports[PB*i +: PB];
		end
		row.typed = typed;
		row.res.port = exp_port;
		row.res.st = exp_st;
		directed_rows.push_back(row);
	endtask

	// called at a rising edge; returns at the edge where the request is taken
	task automatic send_req(input sel_req_t r, input bit typed, input sel_res_t exp,
			input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		flow_hash <= r.hash;
		stage <= r.stage;
		uplink <= r.up;
		option_count <= r.count;
		weight_a <= r.w[0];
		port_a <= r.p[0];
		weight_b <= r.w[1];
		port_b <= r.p[1];
		weight_c <= r.w[2];
		port_c <= r.p[2];
		weight_d <= r.w[3];
		port_d <= r.p[3];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_picks.push_back(typed ? exp : pick_port(r));
		n_sent++;
	endtask

	task automatic wait_empty();
		start <= 1'b0;
		while (pending_picks.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		sel_res_t exp;
		if (arst_n && done) begin
			if (pending_picks.size() == 0) begin
				$display("%0t: unexpected result port=%0d status=%0d", $time,
					chosen_port, status);
				errors++;
			end else begin
				exp = pending_picks.pop_front();
				case (exp.st)
					ST_OK: n_ok++;
					ST_BAD_STAGE: n_bad_stage++;
					default: n_zero_weight++;
				endcase
				if (chosen_port !== exp.port) begin
					$display("%0t: chosen_port expected %0d actual %0d", $time,
						exp.port, chosen_port);
					errors++;
				end
				if (status !== exp.st) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp.st, status);
					errors++;
				end
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("wcmp_output_port_select_core_tb failed");
		$finish;
	end

	initial begin
		sel_req_t r;
		sel_res_t none;
		int gap;
		int kind;
		int wmode;
		bit burst;
		none.port = '0;
		none.st = ST_OK;
		burst = 1'b0;

		// stage zero reports a bad stage, also over an empty weight set
		add_row(32'h0000_0000, 2'd0, 1'b0, 3'd4, {4{16'h0001}}, 32'h0403_0201,
			1'b1, 8'd0, ST_BAD_STAGE);
		add_row(32'hFFFF_FFFF, 2'd0, 1'b1, 3'd0, '0, '1, 1'b1, 8'd0, ST_BAD_STAGE);
		add_row(32'h1234_5678, STAGE_1, 1'b0, 3'd0, {4{16'hFFFF}}, '1,
			1'b1, 8'd0, ST_ZERO_WEIGHT);
		add_row(32'hFFFF_FFFF, STAGE_2, 1'b1, 3'd4, '0, '1, 1'b1, 8'd0, ST_ZERO_WEIGHT);
		// weight outside the active lanes does not count
		add_row(32'hDEAD_BEEF, STAGE_3, 1'b1, 3'd3, {16'h0005, 48'h0}, '1,
			1'b1, 8'd0, ST_ZERO_WEIGHT);
		add_row(32'hFFFF_FFFF, STAGE_1, 1'b0, 3'd1, {48'h0, 16'hFFFF}, {24'h0, 8'hFF},
			1'b1, 8'hFF, ST_OK);
		add_row(32'hFFFF_FFFF, STAGE_2, 1'b1, 3'd1, {48'h0, 16'h0001}, '0,
			1'b1, 8'h00, ST_OK);
		add_row(32'h0000_0000, STAGE_1, 1'b0, 3'd4, {16'h0007, 48'h0}, 32'h4433_2211,
			1'b1, 8'h44, ST_OK);
		// count above the lane limit saturates
		add_row(32'h0000_0003, STAGE_1, 1'b0, 3'd7, {4{16'h0001}}, 32'h1312_1110,
			1'b1, 8'h13, ST_OK);
		add_row(32'h0000_0002, STAGE_1, 1'b1, 3'd5, {4{16'h0001}}, 32'h2322_2120,
			1'b1, 8'h22, ST_OK);
		add_row(32'h0000_0001, STAGE_1, 1'b0, 3'd4, 64'h0000_0001_0000_0001,
			32'hDDCC_BBAA, 1'b0, 8'd0, ST_OK);
		add_row(32'h1234_5678, STAGE_2, 1'b0, 3'd4, 64'h0100_0030_0007_0002,
			32'h0403_0201, 1'b0, 8'd0, ST_OK);
		add_row(32'h1234_5678, STAGE_2, 1'b1, 3'd4, 64'h0100_0030_0007_0002,
			32'h0403_0201, 1'b0, 8'd0, ST_OK);
		add_row(32'h1234_5678, STAGE_3, 1'b0, 3'd4, 64'h0100_0030_0007_0002,
			32'h0403_0201, 1'b0, 8'd0, ST_OK);
		add_row(32'h1234_5678, STAGE_3, 1'b1, 3'd4, 64'h0100_0030_0007_0002,
			32'h0403_0201, 1'b0, 8'd0, ST_OK);
		add_row(32'hFFFF_FFFF, STAGE_3, 1'b0, 3'd4, {4{16'hFFFF}}, 32'hFFFE_FDFC,
			1'b0, 8'd0, ST_OK);
		add_row(32'h8000_0001, STAGE_2, 1'b0, 3'd2, 64'h0000_0000_FFFF_0003,
			32'h0000_5AA5, 1'b0, 8'd0, ST_OK);
		add_row(32'h0F0F_0F0F, STAGE_3, 1'b1, 3'd3, 64'h0000_0009_0000_0005,
			32'h0030_2010, 1'b0, 8'd0, ST_OK);
		add_row(32'hFFFF_FFFE, STAGE_1, 1'b0, 3'd6, 64'h0003_0000_0000_0000,
			32'h77AA_BBCC, 1'b0, 8'd0, ST_OK);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			send_req(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].res,
				$urandom_range(7));
		wait_empty();

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 64 == 0)
				burst = ($urandom_range(3) == 0);
			if (n == N_RANDOM / 2)
				wait_empty();
			r.hash = $urandom;
			r.up = 1'($urandom_range(1));
			kind = $urandom_range(99);
			r.stage = (kind < 8) ? 2'd0 : 2'($urandom_range(3, 1));
			if (kind >= 8 && kind < 14)
				r.count = 3'($urandom_range(7, 5));
			else if (kind >= 14 && kind < 17)
				r.count = 3'd0;
			else
				r.count = 3'($urandom_range(4, 1));
			wmode = $urandom_range(3);
			for (int i = 0; i < LANES; i++) begin
				r.p[i] = PB'($urandom);
				case (wmode)
					0: r.w[i] = WB'($urandom);
					1: r.w[i] = WB'($urandom_range(15));
					2: r.w[i] = $urandom_range(1) ? WB'($urandom_range(15)) : '0;
					default: r.w[i] = ($urandom_range(5) == 0) ? '0 : WB'($urandom);
				endcase
				// all active weights zero, leftover lanes still random
				if (kind >= 17 && kind < 22 && i < r.count)
					r.w[i] = '0;
			end
			gap = burst ? 0 : $urandom_range(7);
			send_req(r, 1'b0, none, gap);
		end

		wait_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests: %0d port picks, %0d bad stage, %0d zero weight",
			n_sent, n_ok, n_bad_stage, n_zero_weight);
		$display("all stages, uplink settings, counts 0..7 and weight mixes exercised");
		if (errors == 0) begin
			$display("wcmp_output_port_select_core_tb passed");
		end else begin
			$display("wcmp_output_port_select_core_tb failed");
		end
		$finish;
	end

endmodule
